// File: src/mdc_pkg.sv
`default_nettype none
package mdc_pkg;

    localparam logic [7:0] BDOT_DIVIDE = 8'd10;

    localparam logic [2:0] LAW_RATE = 3'd3;
    localparam logic [2:0] LAW_BDOT = 3'd4;

    typedef enum logic [1:0] {
        CFG_LAW       = 2'd0,
        CFG_GAIN_ATT  = 2'd1,
        CFG_GAIN_RATE = 2'd2,
        CFG_TORQUE    = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_ZERO_FIELD  = 2'd1,
        ST_INVALID_LAW = 2'd2,
        ST_SAT         = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_NORM,
        S_NWAIT,
        S_NCHK,
        S_CROSS,
        S_GCM,
        S_DIV,
        S_DWAIT,
        S_BDOT,
        S_BMUL,
        S_TCHK,
        S_TORQ,
        S_TWAIT,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        MS_IDLE,
        MS_SQ,
        MS_CRS_P,
        MS_CRS_N,
        MS_GC_LO,
        MS_GC_HI,
        MS_GRATE
    } t_msel;

    typedef enum logic [2:0] {
        AOP_HOLD,
        AOP_LOAD,
        AOP_ADD,
        AOP_SUB,
        AOP_ADDH
    } t_aop;

    typedef enum logic [2:0] {
        D_NONE,
        D_N,
        D_C,
        D_BD,
        D_T
    } t_dst;

    typedef struct packed {
        logic       load;
        t_msel      msel;
        logic [1:0] axis;
        logic       src_m;
        t_aop       aop;
        t_dst       dst;
        logic       set_stat;
        t_status    stat;
        logic       bd_upd;
        logic       div_start;
        logic       div_store;
    } t_cmd;

    typedef struct packed {
        logic       gain_zero;
        logic [2:0] law;
        logic       torque;
        logic       n_zero;
        logic       prev_zero;
        logic       cnt_hit;
        logic       div_done;
    } t_stat;

    function automatic logic [1:0] nxt_axis(input logic [1:0] a);
        return (a == 2'd2) ? 2'd0 : a + 2'd1;
    endfunction

    // {sat, value}: signed 32-bit value from sign and magnitude, clamped
    function automatic logic [32:0] clamp32(input logic neg, input logic [63:0] mag);
        logic [63:0] lim;
        logic [63:0] m;
        logic        sat;
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        sat = (mag > lim);
        m   = sat ? lim : mag;
        return {sat, neg ? (32'd0 - m[31:0]) : m[31:0]};
    endfunction

endpackage
`default_nettype wire

// File: src/mdc_in_if.sv
`default_nettype none
interface mdc_in_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] field_x;
    logic signed [23:0] field_y;
    logic signed [23:0] field_z;
    logic signed [23:0] rel_rate_x;
    logic signed [23:0] rel_rate_y;
    logic signed [23:0] rel_rate_z;
    logic signed [23:0] ref_rate_x;
    logic signed [23:0] ref_rate_y;
    logic signed [23:0] ref_rate_z;

    modport source (
        output valid, field_x, field_y, field_z, rel_rate_x, rel_rate_y, rel_rate_z,
               ref_rate_x, ref_rate_y, ref_rate_z,
        input  ready
    );
    modport sink (
        input  valid, field_x, field_y, field_z, rel_rate_x, rel_rate_y, rel_rate_z,
               ref_rate_x, ref_rate_y, ref_rate_z,
        output ready
    );
endinterface
`default_nettype wire

// File: src/mdc_out_if.sv
`default_nettype none
interface mdc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] command_x;
    logic signed [31:0] command_y;
    logic signed [31:0] command_z;
    logic        [1:0]  status;

    modport source (
        output valid, command_x, command_y, command_z, status,
        input  ready
    );
    modport sink (
        input  valid, command_x, command_y, command_z, status,
        output ready
    );
endinterface
`default_nettype wire

// File: src/magnetorquer_dipole_control_top.sv
`default_nettype none
// Rate damping: field norm, cross product, then per axis a gain multiply and a divide; torque
// mode adds a torque cross product. B-dot computes only on an output sample. A zero field
// (rate damping), zero gain or invalid law goes straight to the output.
// Throughput: one item at a time; input is ready again in the cycle after the result transfer.
// Reset (synchronous, active low): law 3, gains 0, dipole mode, previous field 0, count 1.
module magnetorquer_dipole_control_top
    import mdc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    mdc_in_if.sink           i_in,
    mdc_out_if.source        o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);

    t_cmd  w_cmd;
    t_stat w_stat;

    mdc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    mdc_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_field_x    (i_in.field_x),
        .i_field_y    (i_in.field_y),
        .i_field_z    (i_in.field_z),
        .i_rel_rate_x (i_in.rel_rate_x),
        .i_rel_rate_y (i_in.rel_rate_y),
        .i_rel_rate_z (i_in.rel_rate_z),
        .i_ref_rate_x (i_in.ref_rate_x),
        .i_ref_rate_y (i_in.ref_rate_y),
        .i_ref_rate_z (i_in.ref_rate_z),
        .o_command_x  (o_out.command_x),
        .o_command_y  (o_out.command_y),
        .o_command_z  (o_out.command_z),
        .o_status     (o_out.status)
    );

endmodule
`default_nettype wire

// File: src/mdc_div.sv
`default_nettype none
module mdc_div
    import mdc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [80:0] i_dvd,
    input  wire logic [47:0] i_dsr,
    output logic             o_done,
    output logic [32:0]      o_quo,
    output logic             o_ovf
);

    // quotient of i_dvd / (i_dsr << 20), one bit per cycle
    logic [67:0] r_rem, n_rem;
    logic [32:0] r_dvd;
    logic [32:0] r_quo;
    logic        r_ovf;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [67:0] w_d;
    logic [68:0] w_t;
    logic        w_ge;

    assign w_d  = {i_dsr, 20'd0};
    assign w_t  = {r_rem, r_dvd[32]};
    assign w_ge = (w_t >= {1'b0, w_d});

    always_comb begin
        n_rem = w_ge ? 68'(w_t - {1'b0, w_d}) : w_t[67:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= 6'd33;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {20'd0, i_dvd[80:33]};
            r_dvd <= i_dvd[32:0];
            r_quo <= 33'd0;
            r_ovf <= ({20'd0, i_dvd[80:33]} >= w_d);
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[31:0], 1'b0};
            r_quo <= {r_quo[31:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_ovf  = r_ovf;

endmodule
`default_nettype wire

// File: src/mdc_ctrl.sv
`default_nettype none
module mdc_ctrl
    import mdc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  wire logic  i_out_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    t_state     r_state, n_state;
    logic [2:0] r_step, n_step;
    logic [1:0] r_axis, n_axis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= 3'd0;
            r_axis  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_axis  <= n_axis;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_axis  = r_axis;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                n_step = 3'd0;
                n_axis = 2'd0;
                if (i_stat.gain_zero) n_state = S_OUT;
                else if (i_stat.law == LAW_RATE) n_state = S_NORM;
                else if (i_stat.law == LAW_BDOT) n_state = S_BDOT;
                else n_state = S_OUT;
            end
            S_NORM: begin
                n_step = r_step + 3'd1;
                if (r_step == 3'd2) begin
                    n_state = S_NWAIT;
                    n_step  = 3'd0;
                end
            end
            S_NWAIT: n_state = S_NCHK;
            S_NCHK: begin
                n_step  = 3'd0;
                n_state = i_stat.n_zero ? S_OUT : S_CROSS;
            end
            S_CROSS: begin
                n_step = r_step + 3'd1;
                if (r_step == 3'd5) begin
                    n_state = S_GCM;
                    n_step  = 3'd0;
                    n_axis  = 2'd0;
                end
            end
            S_GCM: begin
                n_step = r_step + 3'd1;
                if (r_step == 3'd2) begin
                    n_state = S_DIV;
                    n_step  = 3'd0;
                end
            end
            S_DIV: n_state = S_DWAIT;
            S_DWAIT: begin
                if (i_stat.div_done) begin
                    if (r_axis == 2'd2) begin
                        n_state = S_TCHK;
                    end else begin
                        n_axis  = nxt_axis(r_axis);
                        n_state = S_GCM;
                    end
                end
            end
            S_BDOT: begin
                n_step  = 3'd0;
                n_state = (!i_stat.prev_zero && i_stat.cnt_hit) ? S_BMUL : S_OUT;
            end
            S_BMUL: begin
                n_step = r_step + 3'd1;
                if (r_step == 3'd2) begin
                    n_state = S_TCHK;
                    n_step  = 3'd0;
                end
            end
            S_TCHK: begin
                n_step  = 3'd0;
                n_state = i_stat.torque ? S_TORQ : S_OUT;
            end
            S_TORQ: begin
                n_step = r_step + 3'd1;
                if (r_step == 3'd5) begin
                    n_state = S_TWAIT;
                    n_step  = 3'd0;
                end
            end
            S_TWAIT: n_state = S_OUT;
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_DISPATCH: begin
                if (!i_stat.gain_zero && i_stat.law != LAW_RATE && i_stat.law != LAW_BDOT) begin
                    o_cmd.set_stat = 1'b1;
                    o_cmd.stat     = ST_INVALID_LAW;
                end
            end
            S_NORM: begin
                o_cmd.msel = MS_SQ;
                o_cmd.axis = r_step[1:0];
                o_cmd.aop  = (r_step == 3'd0) ? AOP_LOAD : AOP_ADD;
                o_cmd.dst  = (r_step == 3'd2) ? D_N : D_NONE;
            end
            S_NCHK: begin
                if (i_stat.n_zero) begin
                    o_cmd.set_stat = 1'b1;
                    o_cmd.stat     = ST_ZERO_FIELD;
                end
            end
            S_CROSS, S_TORQ: begin
                o_cmd.src_m = (r_state == S_TORQ);
                o_cmd.axis  = r_step[2:1];
                o_cmd.msel  = r_step[0] ? MS_CRS_N : MS_CRS_P;
                o_cmd.aop   = r_step[0] ? AOP_SUB : AOP_LOAD;
                if (r_step[0]) o_cmd.dst = (r_state == S_TORQ) ? D_T : D_C;
            end
            S_GCM: begin
                o_cmd.axis = r_axis;
                if (r_step == 3'd0) begin
                    o_cmd.msel = MS_GC_LO;
                    o_cmd.aop  = AOP_LOAD;
                end else if (r_step == 3'd1) begin
                    o_cmd.msel = MS_GC_HI;
                    o_cmd.aop  = AOP_ADDH;
                end
            end
            S_DIV: begin
                o_cmd.axis      = r_axis;
                o_cmd.div_start = 1'b1;
            end
            S_DWAIT: begin
                o_cmd.axis      = r_axis;
                o_cmd.div_store = i_stat.div_done;
            end
            S_BDOT: o_cmd.bd_upd = 1'b1;
            S_BMUL: begin
                o_cmd.msel = MS_GRATE;
                o_cmd.axis = r_step[1:0];
                o_cmd.aop  = AOP_LOAD;
                o_cmd.dst  = D_BD;
            end
            S_OUT: o_out_valid = 1'b1;
            default: o_cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

// File: src/mdc_dp.sv
`default_nettype none
module mdc_dp
    import mdc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [31:0]        i_cfg_data,
    input  wire t_cmd               i_cmd,
    output t_stat                   o_stat,
    input  wire logic signed [23:0] i_field_x,
    input  wire logic signed [23:0] i_field_y,
    input  wire logic signed [23:0] i_field_z,
    input  wire logic signed [23:0] i_rel_rate_x,
    input  wire logic signed [23:0] i_rel_rate_y,
    input  wire logic signed [23:0] i_rel_rate_z,
    input  wire logic signed [23:0] i_ref_rate_x,
    input  wire logic signed [23:0] i_ref_rate_y,
    input  wire logic signed [23:0] i_ref_rate_z,
    output logic signed [31:0]      o_command_x,
    output logic signed [31:0]      o_command_y,
    output logic signed [31:0]      o_command_z,
    output logic [1:0]              o_status
);

    logic [2:0]  r_law;
    logic [31:0] r_gain_att;
    logic [31:0] r_gain_rate;
    logic        r_torque;

    logic signed [23:0] r_b    [3];
    logic signed [24:0] r_w    [3];
    logic signed [23:0] r_prev [3];
    logic signed [29:0] r_rate [3];
    logic signed [49:0] r_c    [3];
    logic signed [31:0] r_m    [3];
    logic signed [31:0] r_t    [3];
    logic [7:0]         r_cnt;
    logic [47:0]        r_n;
    logic               r_sat;
    t_status            r_status;

    logic signed [65:0] r_prod;
    logic signed [83:0] r_acc, n_acc;
    t_aop               r_aop_d;
    t_dst               r_dst_d;
    logic [1:0]         r_axis_d;

    logic signed [32:0] w_ma, w_mb;
    logic signed [32:0] w_u_j, w_u_k, w_v_j, w_v_k;
    logic [1:0]         w_j, w_k;
    logic [49:0]        w_cmag;
    logic [29:0]        w_rmag;
    logic signed [83:0] w_prod_x;
    logic               w_prev_zero;

    logic               w_div_done;
    logic [32:0]        w_quo;
    logic               w_ovf;

    logic signed [63:0] w_t;
    logic [63:0]        w_tmag;
    logic [31:0]        w_tval;
    logic [32:0]        w_bd;
    logic [32:0]        w_dq;

    mdc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_dvd   (r_acc[80:0]),
        .i_dsr   (r_n),
        .o_done  (w_div_done),
        .o_quo   (w_quo),
        .o_ovf   (w_ovf)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_law       <= LAW_RATE;
            r_gain_att  <= 32'd0;
            r_gain_rate <= 32'd0;
            r_torque    <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_LAW:       r_law       <= i_cfg_data[2:0];
                CFG_GAIN_ATT:  r_gain_att  <= i_cfg_data;
                CFG_GAIN_RATE: r_gain_rate <= i_cfg_data;
                CFG_TORQUE:    r_torque    <= i_cfg_data[0];
                default:       r_torque    <= r_torque;
            endcase
        end
    end

    assign w_j = nxt_axis(i_cmd.axis);
    assign w_k = nxt_axis(w_j);
    assign w_prev_zero = (r_prev[0] == 24'sd0) && (r_prev[1] == 24'sd0) &&
                         (r_prev[2] == 24'sd0);

    always_comb begin
        w_u_j = i_cmd.src_m ? {r_m[w_j][31], r_m[w_j]} : {{9{r_b[w_j][23]}}, r_b[w_j]};
        w_u_k = i_cmd.src_m ? {r_m[w_k][31], r_m[w_k]} : {{9{r_b[w_k][23]}}, r_b[w_k]};
        w_v_j = i_cmd.src_m ? {{9{r_b[w_j][23]}}, r_b[w_j]} : {{8{r_w[w_j][24]}}, r_w[w_j]};
        w_v_k = i_cmd.src_m ? {{9{r_b[w_k][23]}}, r_b[w_k]} : {{8{r_w[w_k][24]}}, r_w[w_k]};
        w_cmag = r_c[i_cmd.axis][49] ? 50'(-r_c[i_cmd.axis]) : r_c[i_cmd.axis];
        w_rmag = r_rate[i_cmd.axis][29] ? 30'(-r_rate[i_cmd.axis]) : r_rate[i_cmd.axis];
        w_ma = '0;
        w_mb = '0;
        case (i_cmd.msel)
            MS_SQ: begin
                w_ma = {{9{r_b[i_cmd.axis][23]}}, r_b[i_cmd.axis]};
                w_mb = {{9{r_b[i_cmd.axis][23]}}, r_b[i_cmd.axis]};
            end
            MS_CRS_P: begin
                w_ma = w_u_j;
                w_mb = w_v_k;
            end
            MS_CRS_N: begin
                w_ma = w_u_k;
                w_mb = w_v_j;
            end
            MS_GC_LO: begin
                w_ma = {1'b0, r_gain_rate};
                w_mb = {8'd0, w_cmag[24:0]};
            end
            MS_GC_HI: begin
                w_ma = {1'b0, r_gain_rate};
                w_mb = {8'd0, w_cmag[49:25]};
            end
            MS_GRATE: begin
                w_ma = {1'b0, r_gain_att};
                w_mb = {3'd0, w_rmag};
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
    end

    assign w_prod_x = {{18{r_prod[65]}}, r_prod};

    always_comb begin
        case (r_aop_d)
            AOP_LOAD: n_acc = w_prod_x;
            AOP_ADD:  n_acc = r_acc + w_prod_x;
            AOP_SUB:  n_acc = r_acc - w_prod_x;
            AOP_ADDH: n_acc = r_acc + (w_prod_x <<< 25);
            default:  n_acc = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aop_d  <= AOP_HOLD;
            r_dst_d  <= D_NONE;
            r_axis_d <= 2'd0;
        end else begin
            r_aop_d  <= i_cmd.aop;
            r_dst_d  <= i_cmd.dst;
            r_axis_d <= i_cmd.axis;
        end
    end

    always_comb begin
        w_t    = n_acc[63:0];
        w_tmag = w_t[63] ? 64'(-w_t) : w_t;
        w_tval = 32'(w_tmag[21:0]) * 32'd1000;
        w_bd   = clamp32(r_rate[r_axis_d] > 30'sd0, n_acc[63:0]);
        w_dq   = clamp32(r_c[i_cmd.axis] > 50'sd0, w_ovf ? {64{1'b1}} : {31'd0, w_quo});
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev[0] <= '0;
            r_prev[1] <= '0;
            r_prev[2] <= '0;
            r_cnt     <= 8'd1;
            r_sat     <= 1'b0;
            r_status  <= ST_OK;
        end else begin
            if (i_cmd.load) begin
                r_sat    <= 1'b0;
                r_status <= ST_OK;
            end
            if (i_cmd.set_stat) r_status <= i_cmd.stat;
            if (i_cmd.bd_upd) begin
                for (int i = 0; i < 3; i++) r_prev[i] <= r_b[i];
                if (!w_prev_zero) begin
                    if (r_cnt >= BDOT_DIVIDE) r_cnt <= 8'd1;
                    else r_cnt <= r_cnt + 8'd1;
                end
            end
            if (r_dst_d == D_BD && w_bd[32]) r_sat <= 1'b1;
            if (r_dst_d == D_T && w_tmag > 64'd2147483) r_sat <= 1'b1;
            if (i_cmd.div_store && w_dq[32]) r_sat <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_b[0] <= i_field_x;
            r_b[1] <= i_field_y;
            r_b[2] <= i_field_z;
            r_w[0] <= {i_rel_rate_x[23], i_rel_rate_x} + {i_ref_rate_x[23], i_ref_rate_x};
            r_w[1] <= {i_rel_rate_y[23], i_rel_rate_y} + {i_ref_rate_y[23], i_ref_rate_y};
            r_w[2] <= {i_rel_rate_z[23], i_rel_rate_z} + {i_ref_rate_z[23], i_ref_rate_z};
            for (int i = 0; i < 3; i++) begin
                r_m[i] <= '0;
                r_t[i] <= '0;
            end
        end
        if (i_cmd.bd_upd) begin
            for (int i = 0; i < 3; i++) begin
                r_rate[i] <= ((30'(r_b[i]) - 30'(r_prev[i])) <<< 3) +
                             ((30'(r_b[i]) - 30'(r_prev[i])) <<< 1);
            end
        end
        case (r_dst_d)
            D_N:  r_n <= n_acc[47:0];
            D_C:  r_c[r_axis_d] <= n_acc[49:0];
            D_BD: r_m[r_axis_d] <= w_bd[31:0];
            D_T: begin
                if (w_tmag > 64'd2147483) r_t[r_axis_d] <= w_t[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                else r_t[r_axis_d] <= w_t[63] ? 32'(32'd0 - w_tval) : w_tval;
            end
            default: r_n <= r_n;
        endcase
        if (i_cmd.div_store) r_m[i_cmd.axis] <= w_dq[31:0];
    end

    assign o_stat.gain_zero = (r_gain_att == 32'd0);
    assign o_stat.law       = r_law;
    assign o_stat.torque    = r_torque;
    assign o_stat.n_zero    = (r_n == 48'd0);
    assign o_stat.prev_zero = w_prev_zero;
    assign o_stat.cnt_hit   = (r_cnt >= BDOT_DIVIDE);
    assign o_stat.div_done  = w_div_done;

    assign o_command_x = r_torque ? r_t[0] : r_m[0];
    assign o_command_y = r_torque ? r_t[1] : r_m[1];
    assign o_command_z = r_torque ? r_t[2] : r_m[2];
    assign o_status    = r_sat ? ST_SAT : r_status;

endmodule
`default_nettype wire
